>>> sv/pqsh_pkg.sv
`default_nettype none

package pqsh_pkg;

	// default sizing
	localparam int DEPTH_DEF     = 64;
	localparam int TIME_BITS_DEF = 48;

	// fixed field widths
	localparam int TIME_W   = 48;
	localparam int HANDLE_W = 16;
	localparam int LEN_W    = 16;
	localparam int BYTES_W  = 22;
	localparam int ENTRY_W  = 7;

	// stale threshold after reset: 300 ms in ns
	localparam logic [TIME_W-1:0] THRESH_RESET = 48'd300000000;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// one queue entry as stored in the entry RAM
	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
		logic [TIME_W-1:0]   arrival;
	} entry_t;

endpackage

`default_nettype wire

>>> sv/pqsh_entry_ram.sv
`default_nettype none

module pqsh_entry_ram #(
	parameter int DEPTH = pqsh_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(pqsh_pkg::DEPTH_DEF)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire pqsh_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output pqsh_pkg::entry_t     rdata
);

	pqsh_pkg::entry_t mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/packet_queue_stale_head_drop.sv
// Flow: an input beat is accepted in IDLE, which reads the head entry from the registered RAM port;
// in EVAL a peek drops stale head entries, one RAM read each, and the result is registered once the
// output slot is free. A new item is accepted only after the block has returned to IDLE.
// Reset (arst_n low, asynchronous): queue empty, byte total and lost flag cleared,
// stale threshold back to 300000000 ns; entry RAM contents are not cleared.
`default_nettype none

module packet_queue_stale_head_drop #(
	parameter int DEPTH     = pqsh_pkg::DEPTH_DEF,
	parameter int TIME_BITS = pqsh_pkg::TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [47:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [47:0] now_time,
	input  wire logic [15:0] packet_handle,
	input  wire logic [15:0] payload_len,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      head_handle,
	output logic [15:0]      head_len,
	output logic             lost_flag,
	output logic [6:0]       drops_this_step,
	output logic [21:0]      bytes_in_queue,
	output logic [6:0]       entries_in_queue
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int BT_W  = $clog2(DEPTH * 65535 + 1);
	localparam int NOW_W = (TIME_BITS < pqsh_pkg::TIME_W) ? TIME_BITS : pqsh_pkg::TIME_W;
	localparam int CMP_W = (TIME_BITS > pqsh_pkg::TIME_W) ? TIME_BITS : pqsh_pkg::TIME_W;
	localparam logic [pqsh_pkg::TIME_W-1:0] NOW_MASK =
		{pqsh_pkg::TIME_W{1'b1}} >> (pqsh_pkg::TIME_W - NOW_W);
	localparam logic [CMP_W-1:0] AGE_MASK = {CMP_W{1'b1}} >> (CMP_W - TIME_BITS);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	state_t                      state_q;
	logic [pqsh_pkg::TIME_W-1:0] thr_q;
	pqsh_pkg::mode_t             mode_q;
	logic [pqsh_pkg::TIME_W-1:0] now_q;
	logic [15:0]                 handle_q;
	logic [15:0]                 len_q;
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [BT_W-1:0]             bt_q;
	logic                        lost_q;
	logic [CNT_W-1:0]            drops_q;

	logic                        out_valid_q;
	pqsh_pkg::status_t           status_q;
	logic [15:0]                 hhandle_q;
	logic [15:0]                 hlen_q;
	logic                        lostout_q;
	logic [6:0]                  drops_out_q;
	logic [21:0]                 bytes_q;
	logic [6:0]                  entries_q;

	// RAM ports
	logic                        ram_we;
	logic                        ram_re;
	logic [PTR_W-1:0]            ram_raddr;
	pqsh_pkg::entry_t            ram_wdata;
	pqsh_pkg::entry_t            ram_rdata;

	// evaluation
	logic                        in_fire;
	logic                        empty;
	logic                        full;
	logic                        slot_free;
	logic                        fin;
	logic                        go;
	logic                        do_drop;
	logic [PTR_W-1:0]            head_nxt;
	logic [PTR_W-1:0]            tail_nxt;
	logic [CMP_W-1:0]            age;
	logic                        stale;
	pqsh_pkg::status_t           status_d;
	logic [15:0]                 hhandle_d;
	logic [15:0]                 hlen_d;
	logic [BT_W-1:0]             bt_after;
	logic [CNT_W-1:0]            cnt_after;
	logic                        push_ok;
	logic                        pop_ok;
	logic [BT_W+21:0]            bt_wide;
	logic [CNT_W+6:0]            cnt_wide;
	logic [CNT_W+6:0]            drops_wide;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;

	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == FULL_CNT);
	assign slot_free = !out_valid_q || out_ready;
	assign head_nxt  = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
	assign tail_nxt  = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);

	// head age, modulo the time width
	assign age   = (CMP_W'(now_q) - CMP_W'(ram_rdata.arrival)) & AGE_MASK;
	assign stale = (thr_q != '0) && !empty && (age > CMP_W'(thr_q));

	// head read at accept, and at the new head after each drop
	assign ram_re    = in_fire || do_drop;
	assign ram_raddr = do_drop ? head_nxt : head_q;
	assign ram_we    = go && push_ok;
	assign ram_wdata = '{handle: handle_q, len: len_q, arrival: now_q};

	// decode of the item in evaluation
	always_comb begin
		fin       = 1'b0;
		do_drop   = 1'b0;
		push_ok   = 1'b0;
		pop_ok    = 1'b0;
		status_d  = pqsh_pkg::STAT_OK;
		hhandle_d = '0;
		hlen_d    = '0;
		if (state_q == ST_EVAL) begin
			case (mode_q)
				pqsh_pkg::MODE_PUSH: begin
					fin = 1'b1;
					if (full) begin
						status_d = pqsh_pkg::STAT_FULL;
					end else begin
						push_ok = 1'b1;
					end
				end
				pqsh_pkg::MODE_POP: begin
					fin = 1'b1;
					if (empty) begin
						status_d = pqsh_pkg::STAT_EMPTY;
					end else begin
						pop_ok    = 1'b1;
						hhandle_d = ram_rdata.handle;
						hlen_d    = ram_rdata.len;
					end
				end
				pqsh_pkg::MODE_PEEK: begin
					if (stale) begin
						do_drop = 1'b1;
					end else begin
						fin = 1'b1;
						if (empty) begin
							status_d = pqsh_pkg::STAT_EMPTY;
						end else begin
							hhandle_d = ram_rdata.handle;
							hlen_d    = ram_rdata.len;
						end
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	assign go = fin && slot_free;

	// occupancy after this step
	always_comb begin
		bt_after  = bt_q;
		cnt_after = cnt_q;
		if (push_ok) begin
			bt_after  = bt_q + BT_W'(len_q);
			cnt_after = cnt_q + CNT_W'(1);
		end else if (pop_ok) begin
			bt_after  = bt_q - BT_W'(ram_rdata.len);
			cnt_after = cnt_q - CNT_W'(1);
		end
	end

	assign bt_wide    = {22'd0, bt_after};
	assign cnt_wide   = {7'd0, cnt_after};
	assign drops_wide = {7'd0, drops_q};

	// control and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= pqsh_pkg::THRESH_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			bt_q        <= '0;
			lost_q      <= 1'b0;
			drops_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						drops_q <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (do_drop) begin
						bt_q    <= bt_q - BT_W'(ram_rdata.len);
						cnt_q   <= cnt_q - CNT_W'(1);
						head_q  <= head_nxt;
						lost_q  <= 1'b1;
						drops_q <= drops_q + CNT_W'(1);
					end else if (go) begin
						bt_q  <= bt_after;
						cnt_q <= cnt_after;
						if (push_ok) begin
							tail_q <= tail_nxt;
						end
						if (pop_ok) begin
							head_q <= head_nxt;
						end
						if (mode_q == pqsh_pkg::MODE_CLEAR) begin
							lost_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input beat capture and result register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q   <= pqsh_pkg::mode_t'(mode);
			now_q    <= now_time & NOW_MASK;
			handle_q <= packet_handle;
			len_q    <= payload_len;
		end
		if (go) begin
			status_q    <= status_d;
			hhandle_q   <= hhandle_d;
			hlen_q      <= hlen_d;
			lostout_q   <= lost_q;
			drops_out_q <= drops_wide[6:0];
			bytes_q     <= bt_wide[21:0];
			entries_q   <= cnt_wide[6:0];
		end
	end

	pqsh_entry_ram #(
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign head_handle      = hhandle_q;
	assign head_len         = hlen_q;
	assign lost_flag        = lostout_q;
	assign drops_this_step  = drops_out_q;
	assign bytes_in_queue   = bytes_q;
	assign entries_in_queue = entries_q;

	// occupancy never exceeds the RAM depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count above depth");

	// an empty queue holds no bytes
	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (bt_q == '0))
		else $error("byte total nonzero on empty queue");

	// stale drops only happen during a peek with a live threshold
	a_drop_peek: assert property (@(posedge clk) disable iff (!arst_n)
		do_drop |-> (mode_q == pqsh_pkg::MODE_PEEK) && (thr_q != '0) && !empty)
		else $error("drop outside peek");

	// a new result only appears from the evaluation state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EVAL))
		else $error("result without evaluation");

	// a push never writes into a full queue
	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("write into full queue");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

	import pqsh_pkg::*;

	localparam int QDEPTH        = DEPTH_DEF;
	localparam int SETTLE_CYCLES = 80;      // settle time after draining, with margin for peeks that drop entries
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_CAP     = 100;

	// one operation as presented on the input channel
	typedef struct packed {
		mode_t               mode;
		logic [TIME_W-1:0]   now;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0]    len;
		logic [3:0]          gap;
	} queue_op_t;

	// one result beat
	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] head_handle;
		logic [LEN_W-1:0]    head_len;
		logic                lost;
		logic [ENTRY_W-1:0]  drops;
		logic [BYTES_W-1:0]  bytes;
		logic [ENTRY_W-1:0]  entries;
	} queue_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TIME_W-1:0] cfg_data  = '0;

	logic                in_valid      = 1'b0;
	logic                in_ready;
	mode_t               in_mode       = MODE_PUSH;
	logic [TIME_W-1:0]   now_time      = '0;
	logic [HANDLE_W-1:0] packet_handle = '0;
	logic [LEN_W-1:0]    payload_len   = '0;

	logic                out_valid;
	logic                out_ready = 1'b1;
	logic [1:0]          status;
	logic [HANDLE_W-1:0] head_handle;
	logic [LEN_W-1:0]    head_len;
	logic                lost_flag;
	logic [ENTRY_W-1:0]  drops_this_step;
	logic [BYTES_W-1:0]  bytes_in_queue;
	logic [ENTRY_W-1:0]  entries_in_queue;

	packet_queue_stale_head_drop i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (in_mode),
		.now_time         (now_time),
		.packet_handle    (packet_handle),
		.payload_len      (payload_len),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.head_handle      (head_handle),
		.head_len         (head_len),
		.lost_flag        (lost_flag),
		.drops_this_step  (drops_this_step),
		.bytes_in_queue   (bytes_in_queue),
		.entries_in_queue (entries_in_queue)
	);

	// shadow copy of the queue
	logic [HANDLE_W-1:0] mdl_handle  [QDEPTH];
	logic [LEN_W-1:0]    mdl_len     [QDEPTH];
	logic [TIME_W-1:0]   mdl_arrival [QDEPTH];
	int                  mdl_head    = 0;
	int                  mdl_tail    = 0;
	logic [ENTRY_W-1:0]  mdl_count   = '0;
	logic [22:0]         mdl_bytes   = '0;
	logic                mdl_lost    = 1'b0;
	logic [TIME_W-1:0]   mdl_thresh  = THRESH_RESET;

	queue_op_t     ops_to_send [$];
	queue_result_t results_due [$];
	queue_op_t     op_on_bus;

	int                error_count = 0;
	int                cycle_count = 0;
	int                ops_made    = 0;
	int                idle_run    = 0;
	int                stall_left  = 0;
	logic              calm_out    = 1'b0;
	logic [TIME_W-1:0] sim_clock   = '0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic void retire_head();
		mdl_bytes = mdl_bytes - mdl_len[mdl_head];
		mdl_head  = (mdl_head == QDEPTH - 1) ? 0 : mdl_head + 1;
		mdl_count = mdl_count - 1'b1;
	endfunction

	// apply one operation to the shadow queue and return the result it should produce
	function automatic queue_result_t advance_queue_model(input queue_op_t op);
		queue_result_t     r;
		logic [TIME_W-1:0] age;
		logic              scanning;
		logic              lost_taken;
		r          = '0;
		r.status   = STAT_OK;
		lost_taken = 1'b0;
		case (op.mode)
			MODE_PUSH: begin
				if (mdl_count >= QDEPTH) begin
					r.status = STAT_FULL;
				end else begin
					mdl_handle[mdl_tail]  = op.handle;
					mdl_len[mdl_tail]     = op.len;
					mdl_arrival[mdl_tail] = op.now;
					mdl_tail  = (mdl_tail == QDEPTH - 1) ? 0 : mdl_tail + 1;
					mdl_count = mdl_count + 1'b1;
					mdl_bytes = mdl_bytes + op.len;
				end
			end
			MODE_POP: begin
				if (mdl_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.head_handle = mdl_handle[mdl_head];
					r.head_len    = mdl_len[mdl_head];
					retire_head();
				end
			end
			MODE_PEEK: begin
				// drop stale heads; age wraps with the time field
				scanning = (mdl_thresh != 0);
				while (scanning && mdl_count != 0) begin
					age = op.now - mdl_arrival[mdl_head];
					if (age <= mdl_thresh) begin
						scanning = 1'b0;
					end else begin
						retire_head();
						mdl_lost = 1'b1;
						r.drops  = r.drops + 1'b1;
					end
				end
				if (mdl_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.head_handle = mdl_handle[mdl_head];
					r.head_len    = mdl_len[mdl_head];
				end
			end
			default: begin
				r.lost     = mdl_lost;
				mdl_lost   = 1'b0;
				lost_taken = 1'b1;
			end
		endcase
		if (!lost_taken)
			r.lost = mdl_lost;
		r.bytes   = mdl_bytes[BYTES_W-1:0];
		r.entries = mdl_count;
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// spacing between operations, scaled so a fraction of entries ages out
	function automatic logic [TIME_W-1:0] time_step();
		if (mdl_thresh == 0 || mdl_thresh[TIME_W-1:40] != 0)
			return $urandom_range(0, 1000000);
		return rand48() % (mdl_thresh / 4 + 2);
	endfunction

	// time jump ahead of a peek, around the threshold
	function automatic logic [TIME_W-1:0] time_jump();
		if (mdl_thresh == 0 || mdl_thresh[TIME_W-1:40] != 0)
			return rand48();
		return rand48() % (mdl_thresh * 2 + 2);
	endfunction

	task automatic add_op(input mode_t m, input logic [TIME_W-1:0] t, input logic [15:0] h,
			input logic [15:0] l, input logic quiet);
		queue_op_t op;
		op.mode   = m;
		op.now    = t;
		op.handle = h;
		op.len    = l;
		op.gap    = quiet ? 4'd0 : 4'($urandom_range(0, 15));
		ops_to_send.push_back(op);
		ops_made++;
	endtask

	task automatic write_threshold(input logic [TIME_W-1:0] value);
		@(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		mdl_thresh = value;
	endtask

	task automatic drain_and_settle();
		while (ops_to_send.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// boundary cases at the reset threshold and near the time wrap
	task automatic run_directed();
		logic [TIME_W-1:0] thr;
		logic [TIME_W-1:0] near_wrap;
		thr       = THRESH_RESET;
		near_wrap = 48'hFFFF_FFFF_FFF6;
		add_op(MODE_POP,   48'd0, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_PEEK,  48'd0, 16'hFFFF, 16'hFFFF, 1'b0);
		add_op(MODE_CLEAR, 48'd0, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_PUSH,  48'd0, 16'h0000, 16'h0000, 1'b1);
		add_op(MODE_PUSH,  48'd1000, 16'hFFFF, 16'hFFFF, 1'b1);
		// age equal to the threshold is not stale, one more ns is
		add_op(MODE_PEEK,  thr, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_PEEK,  thr + 48'd1, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_CLEAR, thr + 48'd1, 16'h0000, 16'h0000, 1'b1);
		add_op(MODE_CLEAR, thr + 48'd2, 16'h0000, 16'h0000, 1'b1);
		add_op(MODE_POP,   thr + 48'd3, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_POP,   thr + 48'd4, 16'h0000, 16'h0000, 1'b0);
		// arrival just below the wrap point
		add_op(MODE_PUSH,  near_wrap, 16'h1234, 16'h0001, 1'b0);
		add_op(MODE_PEEK,  48'd5, 16'h0000, 16'h0000, 1'b0);
		// peek that drops every entry
		add_op(MODE_PEEK,  near_wrap + thr + 48'd1, 16'h0000, 16'h0000, 1'b1);
		add_op(MODE_PUSH,  48'hFFFF_FFFF_FFFF, 16'hABCD, 16'h8000, 1'b0);
		add_op(MODE_PUSH,  48'd0, 16'h5555, 16'hAAAA, 1'b0);
		add_op(MODE_PEEK,  48'd1, 16'h0000, 16'h0000, 1'b1);
		add_op(MODE_POP,   48'd2, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_POP,   48'd3, 16'h0000, 16'h0000, 1'b0);
		add_op(MODE_CLEAR, 48'd4, 16'h0000, 16'h0000, 1'b0);
	endtask

	// bursts of pushes, pops and peeks (some followed by a clear) on a running clock, plus random noise
	task automatic gen_traffic(input int count);
		int   stop_at;
		int   seg;
		int   burst;
		int   k;
		logic quiet;
		stop_at = ops_made + count;
		while (ops_made < stop_at) begin
			seg   = $urandom_range(0, 99);
			quiet = ($urandom_range(0, 4) == 0);
			if (seg < 35) begin
				burst = $urandom_range(1, 70);
				for (k = 0; k < burst; k++) begin
					sim_clock = sim_clock + time_step();
					add_op(MODE_PUSH, sim_clock, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), quiet);
				end
			end else if (seg < 55) begin
				burst = $urandom_range(1, 20);
				for (k = 0; k < burst; k++) begin
					sim_clock = sim_clock + time_step();
					add_op(MODE_POP, sim_clock, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), quiet);
				end
			end else if (seg < 75) begin
				sim_clock = sim_clock + time_jump();
				burst = $urandom_range(1, 3);
				for (k = 0; k < burst; k++) begin
					add_op(MODE_PEEK, sim_clock, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), quiet);
					sim_clock = sim_clock + time_step();
				end
				if ($urandom_range(0, 1) == 0)
					add_op(MODE_CLEAR, sim_clock, 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), quiet);
			end else begin
				burst = $urandom_range(1, 8);
				for (k = 0; k < burst; k++)
					add_op(mode_t'($urandom_range(0, 3)), rand48(),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), quiet);
			end
		end
	endtask

	// main sequence: reset, directed cases, then phases at several thresholds
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		sim_clock = 48'd2000000000;
		gen_traffic(150);
		drain_and_settle();

		write_threshold('0);
		gen_traffic(120);
		drain_and_settle();

		write_threshold(48'd1);
		gen_traffic(120);
		drain_and_settle();

		write_threshold(48'hFFFF_FFFF_FFFF);
		gen_traffic(100);
		drain_and_settle();

		write_threshold(48'($urandom_range(100, 100000)));
		sim_clock = 48'hFFFF_FFF0_0000;
		gen_traffic(120);
		drain_and_settle();

		write_threshold(THRESH_RESET);
		gen_traffic(140);
		drain_and_settle();

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// input driver: one beat per queued operation, with a drawn gap before each
	always @(posedge clk or negedge arst_n) begin : drive_ops
		if (!arst_n) begin
			in_valid <= 1'b0;
			idle_run = 0;
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(advance_queue_model(op_on_bus));
			if (!in_valid || in_ready) begin
				if (ops_to_send.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_run < ops_to_send[0].gap) begin
					idle_run++;
					in_valid <= 1'b0;
				end else begin
					op_on_bus = ops_to_send.pop_front();
					idle_run  = 0;
					in_mode       <= op_on_bus.mode;
					now_time      <= op_on_bus.now;
					packet_handle <= op_on_bus.handle;
					payload_len   <= op_on_bus.len;
					in_valid      <= 1'b1;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin : check_results
		queue_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_error("result beat with no operation outstanding");
			end else begin
				want = results_due.pop_front();
				check_field("status", status, want.status);
				check_field("head_handle", head_handle, want.head_handle);
				check_field("head_len", head_len, want.head_len);
				check_field("lost_flag", lost_flag, want.lost);
				check_field("drops_this_step", drops_this_step, want.drops);
				check_field("bytes_in_queue", bytes_in_queue, want.bytes);
				check_field("entries_in_queue", entries_in_queue, want.entries);
			end
			// occasionally switch between stalling and a stall-free stretch
			if ($urandom_range(0, 39) == 0)
				calm_out = !calm_out;
			stall_left = calm_out ? 0 : $urandom_range(0, 15);
			out_ready <= (stall_left == 0);
		end else if (!out_ready) begin
			if (stall_left > 0)
				stall_left--;
			if (stall_left == 0)
				out_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			report_error($sformatf("timeout, %0d operations unsent, %0d results outstanding",
				ops_to_send.size(), results_due.size()));
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
